// ----- rtl/two_level_per_address_branch_predictor_core_macros.svh -----
// Assertion macros shared by the branch predictor RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TWO_LEVEL_PER_ADDRESS_BRANCH_PREDICTOR_CORE_MACROS_SVH
`define TWO_LEVEL_PER_ADDRESS_BRANCH_PREDICTOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLPAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLPAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tlpap_pkg.sv -----
// Shared types, constants and helpers of the two-level branch predictor.
// No dependencies; used by every other file of the block but the RAM and the macro header.
`timescale 1ns / 1ps

package tlpap_pkg;

    // Default configuration
    localparam int ADDR_BITS_DEF   = 10;
    localparam int SEL_BITS_DEF    = 4;
    localparam int HISTORY_LEN_DEF = 8;
    localparam int CLASS_COUNT_DEF = 6;

    // Fixed field widths
    localparam int ADDR_W  = 32;
    localparam int CLASS_W = 3;
    localparam int COUNT_W = 32;
    localparam int CTR_W   = 2;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CTR_W-1:0]   ctr_t;

    // Saturating counter limits and prediction threshold
    localparam ctr_t   CTR_MAX     = 2'd3;
    localparam ctr_t   CTR_MIN     = 2'd0;
    localparam ctr_t   CTR_WEAK_NT = 2'd1;
    localparam count_t COUNT_MAX   = '1;

    // Pipeline control handed to each stage
    typedef struct packed {
        logic advance;   // every stage moves on this edge
        logic clearing;  // tables are being swept to zero
    } pipe_ctrl_t;

    function automatic count_t sat_inc(input count_t v);
        sat_inc = (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

    function automatic ctr_t ctr_update(input ctr_t c, input logic tk);
        if (tk)
            ctr_update = (c == CTR_MAX) ? c : c + ctr_t'(1);
        else
            ctr_update = (c == CTR_MIN) ? c : c - ctr_t'(1);
    endfunction

endpackage

// ----- rtl/tlpap_in_if.sv -----
// Input channel carrying one resolved branch word per handshake.
// Depends on tlpap_pkg for field widths.
`timescale 1ns / 1ps

interface tlpap_in_if;
    import tlpap_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  branch_address;
    logic               taken;
    logic [CLASS_W-1:0] branch_class;

    modport source (output valid, output branch_address, output taken,
                    output branch_class, input ready);
    modport sink   (input valid, input branch_address, input taken,
                    input branch_class, output ready);
endinterface

// ----- rtl/tlpap_out_if.sv -----
// Output channel carrying one prediction result word per handshake.
// Depends on tlpap_pkg for field widths.
`timescale 1ns / 1ps

interface tlpap_out_if;
    import tlpap_pkg::*;

    logic   valid;
    logic   ready;
    logic   predicted_taken;
    logic   prediction_correct;
    count_t class_total;
    count_t class_correct;

    modport source (output valid, output predicted_taken, output prediction_correct,
                    output class_total, output class_correct, input ready);
    modport sink   (input valid, input predicted_taken, input prediction_correct,
                    input class_total, input class_correct, output ready);
endinterface

// ----- rtl/tlpap_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tlpap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/tlpap_history.sv -----
// First stage: per-address history lookup, history update and counter index.
// Depends on tlpap_pkg and tlpap_ram.
`timescale 1ns / 1ps

module tlpap_history #(
    parameter int ADDR_BITS   = tlpap_pkg::ADDR_BITS_DEF,
    parameter int SEL_BITS    = tlpap_pkg::SEL_BITS_DEF,
    parameter int HISTORY_LEN = tlpap_pkg::HISTORY_LEN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tlpap_pkg::pipe_ctrl_t            ctrl,
    input  logic [ADDR_BITS-1:0]             clear_addr,
    input  logic                             accept,
    input  logic [tlpap_pkg::ADDR_W-1:0]     branch_address,
    input  logic                             taken,
    input  logic [tlpap_pkg::CLASS_W-1:0]    branch_class,
    output logic                             s1_valid,
    output logic                             s1_taken,
    output logic [tlpap_pkg::CLASS_W-1:0]    s1_class,
    output logic [HISTORY_LEN+SEL_BITS-1:0]  s1_cidx
);
    import tlpap_pkg::*;

    localparam int HIST_DEPTH = 1 << ADDR_BITS;
    localparam int CTR_AW     = HISTORY_LEN + SEL_BITS;
    localparam int SEL_SHIFT  = ADDR_BITS / 2;

    logic                   s1_valid_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;
    logic                   s1_taken_reg;
    logic [CLASS_W-1:0]     s1_class_reg;
    logic                   fwd_valid_reg;
    logic [ADDR_BITS-1:0]   fwd_addr_reg;
    logic [HISTORY_LEN-1:0] fwd_data_reg;

    logic [ADDR_BITS-1:0]   s1_hidx;
    logic [HISTORY_LEN-1:0] hist_ram_q;
    logic [HISTORY_LEN-1:0] hist_cur;
    logic [HISTORY_LEN-1:0] hist_new;
    logic [ADDR_W-1:0]      sel_w;
    logic [ADDR_W-1:0]      cidx_w;
    logic                   hist_we;
    logic [ADDR_BITS-1:0]   hist_waddr;
    logic [HISTORY_LEN-1:0] hist_wdata;

    tlpap_ram #(
        .WIDTH (HISTORY_LEN),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (ctrl.advance),
        .raddr (branch_address[ADDR_BITS-1:0]),
        .rdata (hist_ram_q)
    );

    // Bypass the history written on the previous edge, missed by the RAM read
    always_comb
    begin
        s1_hidx  = s1_addr_reg[ADDR_BITS-1:0];
        hist_cur = (fwd_valid_reg && fwd_addr_reg == s1_hidx) ? fwd_data_reg : hist_ram_q;
        hist_new = HISTORY_LEN'({hist_cur, s1_taken_reg});
        sel_w    = (s1_addr_reg >> SEL_SHIFT) & ((ADDR_W'(1) << SEL_BITS) - ADDR_W'(1));
        cidx_w   = (ADDR_W'(hist_cur) << SEL_BITS) | sel_w;
    end

    // Write port: zero sweep after reset, else the shifted history
    always_comb
    begin
        hist_we    = ctrl.clearing || (s1_valid_reg && ctrl.advance);
        hist_waddr = ctrl.clearing ? clear_addr : s1_hidx;
        hist_wdata = ctrl.clearing ? '0 : hist_new;
    end

    // Stage and bypass registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            s1_addr_reg  <= branch_address;
            s1_taken_reg <= taken;
            s1_class_reg <= branch_class;
            fwd_addr_reg <= s1_hidx;
            fwd_data_reg <= hist_new;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_taken = s1_taken_reg;
    assign s1_class = s1_class_reg;
    assign s1_cidx  = cidx_w[CTR_AW-1:0];
endmodule

// ----- rtl/tlpap_counter.sv -----
// Second stage: pattern counter lookup, prediction and counter update.
// Depends on tlpap_pkg and tlpap_ram.
`timescale 1ns / 1ps

module tlpap_counter #(
    parameter int SEL_BITS    = tlpap_pkg::SEL_BITS_DEF,
    parameter int HISTORY_LEN = tlpap_pkg::HISTORY_LEN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tlpap_pkg::pipe_ctrl_t            ctrl,
    input  logic [HISTORY_LEN+SEL_BITS-1:0]  clear_addr,
    input  logic                             s1_valid,
    input  logic                             s1_taken,
    input  logic [tlpap_pkg::CLASS_W-1:0]    s1_class,
    input  logic [HISTORY_LEN+SEL_BITS-1:0]  s1_cidx,
    output logic                             s2_valid,
    output logic                             s2_pred,
    output logic                             s2_taken,
    output logic [tlpap_pkg::CLASS_W-1:0]    s2_class
);
    import tlpap_pkg::*;

    localparam int CTR_AW    = HISTORY_LEN + SEL_BITS;
    localparam int CTR_DEPTH = 1 << CTR_AW;

    logic               s2_valid_reg;
    logic               s2_taken_reg;
    logic [CLASS_W-1:0] s2_class_reg;
    logic [CTR_AW-1:0]  s2_cidx_reg;
    logic               fwd_valid_reg;
    logic [CTR_AW-1:0]  fwd_addr_reg;
    ctr_t               fwd_data_reg;

    ctr_t              ctr_ram_q;
    ctr_t              ctr_cur;
    ctr_t              ctr_new;
    logic              ctr_we;
    logic [CTR_AW-1:0] ctr_waddr;
    ctr_t              ctr_wdata;

    tlpap_ram #(
        .WIDTH (CTR_W),
        .DEPTH (CTR_DEPTH)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (ctrl.advance),
        .raddr (s1_cidx),
        .rdata (ctr_ram_q)
    );

    // Bypass the counter written on the previous edge, then step it
    always_comb
    begin
        ctr_cur = (fwd_valid_reg && fwd_addr_reg == s2_cidx_reg) ? fwd_data_reg : ctr_ram_q;
        ctr_new = ctr_update(ctr_cur, s2_taken_reg);
    end

    // Write port: zero sweep after reset, else the stepped counter
    always_comb
    begin
        ctr_we    = ctrl.clearing || (s2_valid_reg && ctrl.advance);
        ctr_waddr = ctrl.clearing ? clear_addr : s2_cidx_reg;
        ctr_wdata = ctrl.clearing ? CTR_MIN : ctr_new;
    end

    // Stage and bypass registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            s2_valid_reg  <= s1_valid;
            fwd_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            s2_taken_reg <= s1_taken;
            s2_class_reg <= s1_class;
            s2_cidx_reg  <= s1_cidx;
            fwd_addr_reg <= s2_cidx_reg;
            fwd_data_reg <= ctr_new;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_pred  = (ctr_cur > CTR_WEAK_NT);
    assign s2_taken = s2_taken_reg;
    assign s2_class = s2_class_reg;
endmodule

// ----- rtl/tlpap_stats.sv -----
// Final stage: per-class saturating counts and the result register.
// Depends on tlpap_pkg and the assertion macro header.
`timescale 1ns / 1ps

module tlpap_stats #(
    parameter int CLASS_COUNT = tlpap_pkg::CLASS_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlpap_pkg::pipe_ctrl_t         ctrl,
    input  logic                          s2_valid,
    input  logic                          s2_pred,
    input  logic                          s2_taken,
    input  logic [tlpap_pkg::CLASS_W-1:0] s2_class,
    output logic                          out_valid,
    output logic                          out_pred,
    output logic                          out_correct,
    output tlpap_pkg::count_t             out_total,
    output tlpap_pkg::count_t             out_hits
);
    import tlpap_pkg::*;
    `include "two_level_per_address_branch_predictor_core_macros.svh"

    count_t total_reg [CLASS_COUNT];
    count_t hits_reg  [CLASS_COUNT];
    logic   out_valid_reg;
    logic   out_pred_reg;
    logic   out_correct_reg;
    count_t out_total_reg;
    count_t out_hits_reg;

    logic [CLASS_COUNT-1:0] class_hit;
    logic                   in_range;
    logic                   correct;
    count_t                 sel_total;
    count_t                 sel_hits;
    count_t                 new_total;
    count_t                 new_hits;

    // Select the class counts and form the updated values
    always_comb
    begin
        sel_total = '0;
        sel_hits  = '0;
        for (int i = 0; i < CLASS_COUNT; i++)
        begin
            class_hit[i] = (int'(s2_class) == i);
            if (class_hit[i])
            begin
                sel_total = total_reg[i];
                sel_hits  = hits_reg[i];
            end
        end
        in_range  = |class_hit;
        correct   = (s2_pred == s2_taken);
        new_total = sat_inc(sel_total);
        new_hits  = correct ? sat_inc(sel_hits) : sel_hits;
    end

    // Update the counts of the item leaving the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                total_reg[i] <= '0;
                hits_reg[i]  <= '0;
            end
        end
        else if (ctrl.advance && s2_valid)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                if (class_hit[i])
                begin
                    total_reg[i] <= new_total;
                    hits_reg[i]  <= new_hits;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            out_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            out_pred_reg    <= s2_pred;
            out_correct_reg <= correct;
            out_total_reg   <= in_range ? new_total : '0;
            out_hits_reg    <= in_range ? new_hits : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_pred    = out_pred_reg;
    assign out_correct = out_correct_reg;
    assign out_total   = out_total_reg;
    assign out_hits    = out_hits_reg;

    // Correct count never runs ahead of the total count
    `TLPAP_ASSERT_NOW(a_hits_le_total, clk, rst_n, out_valid_reg, out_hits_reg <= out_total_reg, "class hit count above class total")
    // A wrong prediction never adds to the correct count of a class
    `TLPAP_ASSERT_NEXT(a_miss_holds_hits, clk, rst_n, ctrl.advance && s2_valid && !correct && in_range, out_hits_reg == $past(sel_hits), "miss changed the class hit count")
endmodule

// ----- rtl/two_level_per_address_branch_predictor_core.sv -----
// Two-level per-address branch predictor: one resolved branch in, one result out
// per handshake. After reset the block sweeps its history and pattern tables to
// zero, stepping a sweep address through 2**max(ADDR_BITS, HISTORY_LEN+SEL_BITS)
// values (4096 by default), and takes no branch until the sweep ends. Each result
// passes the history RAM read, counter RAM read and result register; back-to-back
// branches that hit the same history or counter entry see the freshly written
// value through bypass registers. The whole pipeline stalls only while a result
// waits at the output; otherwise it accepts one branch every cycle.
// Depends on tlpap_pkg, tlpap_in_if, tlpap_out_if, tlpap_history,
// tlpap_counter, tlpap_stats and the assertion macro header.
`timescale 1ns / 1ps

module two_level_per_address_branch_predictor_core #(
    parameter int ADDR_BITS   = tlpap_pkg::ADDR_BITS_DEF,
    parameter int SEL_BITS    = tlpap_pkg::SEL_BITS_DEF,
    parameter int HISTORY_LEN = tlpap_pkg::HISTORY_LEN_DEF,
    parameter int CLASS_COUNT = tlpap_pkg::CLASS_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tlpap_in_if.sink    branch,
    tlpap_out_if.source result
);
    import tlpap_pkg::*;
    `include "two_level_per_address_branch_predictor_core_macros.svh"

    localparam int CTR_AW = HISTORY_LEN + SEL_BITS;
    localparam int CLR_W  = (ADDR_BITS > CTR_AW) ? ADDR_BITS : CTR_AW;

    logic               clearing_reg;
    logic [CLR_W-1:0]   clear_cnt_reg;
    pipe_ctrl_t         ctrl;
    logic               accept;
    logic               out_valid;

    logic               s1_valid;
    logic               s1_taken;
    logic [CLASS_W-1:0] s1_class;
    logic [CTR_AW-1:0]  s1_cidx;
    logic               s2_valid;
    logic               s2_pred;
    logic               s2_taken;
    logic [CLASS_W-1:0] s2_class;

    // Advance the whole pipeline unless a result is held at the output
    always_comb
    begin
        ctrl.advance  = !out_valid || result.ready;
        ctrl.clearing = clearing_reg;
        branch.ready  = ctrl.advance && !clearing_reg;
        accept        = branch.valid && branch.ready;
    end

    // Table sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + CLR_W'(1);
            if (clear_cnt_reg == '1)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    tlpap_history #(
        .ADDR_BITS   (ADDR_BITS),
        .SEL_BITS    (SEL_BITS),
        .HISTORY_LEN (HISTORY_LEN)
    ) u_history (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .clear_addr     (clear_cnt_reg[ADDR_BITS-1:0]),
        .accept         (accept),
        .branch_address (branch.branch_address),
        .taken          (branch.taken),
        .branch_class   (branch.branch_class),
        .s1_valid       (s1_valid),
        .s1_taken       (s1_taken),
        .s1_class       (s1_class),
        .s1_cidx        (s1_cidx)
    );

    tlpap_counter #(
        .SEL_BITS    (SEL_BITS),
        .HISTORY_LEN (HISTORY_LEN)
    ) u_counter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .clear_addr (clear_cnt_reg[CTR_AW-1:0]),
        .s1_valid   (s1_valid),
        .s1_taken   (s1_taken),
        .s1_class   (s1_class),
        .s1_cidx    (s1_cidx),
        .s2_valid   (s2_valid),
        .s2_pred    (s2_pred),
        .s2_taken   (s2_taken),
        .s2_class   (s2_class)
    );

    tlpap_stats #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .s2_valid    (s2_valid),
        .s2_pred     (s2_pred),
        .s2_taken    (s2_taken),
        .s2_class    (s2_class),
        .out_valid   (out_valid),
        .out_pred    (result.predicted_taken),
        .out_correct (result.prediction_correct),
        .out_total   (result.class_total),
        .out_hits    (result.class_correct)
    );

    assign result.valid = out_valid;

    // Sweep ends only after the last table entry is written
    `TLPAP_ASSERT_NOW(a_sweep_complete, clk, rst_n, $fell(clearing_reg), $past(clear_cnt_reg) == '1, "table sweep ended early")
    // Nothing is in flight while the tables are swept
    `TLPAP_ASSERT_NOW(a_sweep_empty, clk, rst_n, clearing_reg, !out_valid && !s1_valid && !s2_valid, "word in flight during table sweep")
    // No word enters while a finished result is stalled at the output
    `TLPAP_ASSERT_NOW(a_no_accept_on_stall, clk, rst_n, accept, !(out_valid && !result.ready), "word accepted while output stalled")
    // An accepted word reaches the first stage on the next edge
    `TLPAP_ASSERT_NEXT(a_accept_to_stage, clk, rst_n, accept, s1_valid, "accepted word lost before first stage")
endmodule
